[hw/rtl/sfpf_pkg.sv]
package sfpf_pkg;

    localparam int PAGE_BYTES_DEF  = 512;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ADDR_W          = 24;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] CMD_PROGRAM = 8'h82;
    localparam logic [BYTE_W-1:0] CMD_READ    = 8'h03;
    localparam logic [BYTE_W-1:0] DUMMY_BYTE  = 8'hA5;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_CMD      = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ADDR_HI  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ADDR_MID = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ADDR_LO  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DATA     = 3'd4;

    // one classified input transaction, as handed from front to back
    typedef struct packed {
        logic              hdr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              sel_end;
        logic              wait_rdy;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/spi_flash_page_split_framer_top.sv]
// serial flash page program / read framer
// input channel s_*: one buffer byte per transaction; tuser[1] marks the first
// byte of a buffer transfer, whose tdata also carries the start address and
// whose tuser[0] selects read or write; tlast marks the transfer's final byte
// output channel m_*: one serial flash byte per transaction, tuser carries the
// chip select, busy poll and capture marks, tlast ends the results of one input
// a byte that opens a frame gives five results (command, three address bytes,
// data), any other byte gives one; writes are cut at every PAGE_BYTES boundary
// (PAGE_BYTES a power of two)
// an accepted input is written into the queue before its first result is loaded
// into the output register; throughput: one output transaction per cycle while
// m_tready is high, so one input per cycle inside a frame; at a frame start the
// five-byte sequence is set by the output register and the QUEUE_DEPTH entry queue
// between the classifier and the sequencer fills, dropping s_tready while it is full
// reset: address 0, no frame open, write mode; queue and output are emptied
// when m_tready is low the output holds its transaction and the queue absorbs
// further inputs until full
module spi_flash_page_split_framer_top
    import sfpf_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // start_address, write_data
    input  logic [1:0]  s_tuser,   // operation, first_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // spi_byte
    output logic [3:0]  m_tuser,   // select_begin, select_end, wait_ready, capture
    output logic        m_tlast    // last
);

    job_t      job_in;
    job_t      job_out;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    sfpf_front #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .operation    (s_tuser[0]),
        .start_address(s_tdata[23:0]),
        .write_data   (s_tdata[31:24]),
        .first_byte   (s_tuser[1]),
        .final_byte   (s_tlast),
        .job          (job_in)
    );

    sfpf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (push),
        .wr_data(job_in),
        .rd_en  (pop),
        .rd_data(job_out),
        .status (q_status)
    );

    sfpf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job     (job_out),
        .q_status(q_status),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

[hw/rtl/sfpf_queue.sv]
module sfpf_queue
    import sfpf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_en,
    input  job_t      wr_data,
    input  logic      rd_en,
    output job_t      rd_data,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/sfpf_front.sv]
module sfpf_front
    import sfpf_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic              operation,
    input  logic [ADDR_W-1:0] start_address,
    input  logic [BYTE_W-1:0] write_data,
    input  logic              first_byte,
    input  logic              final_byte,
    output job_t              job
);

    localparam int PG_W = $clog2(PAGE_BYTES);
    localparam logic [PG_W-1:0] PG_LAST = PG_W'(PAGE_BYTES - 1);

    logic [ADDR_W-1:0] next_address_reg, next_address_next;
    logic              frame_open_reg, frame_open_next;
    logic              read_mode_reg, read_mode_next;
    logic [ADDR_W-1:0] addr;
    logic              open_now;
    logic              page_end;
    logic              close;

    always_comb begin
        read_mode_next = first_byte ? operation : read_mode_reg;
        addr           = first_byte ? start_address : next_address_reg;
        open_now       = first_byte ? 1'b0 : frame_open_reg;
        page_end       = (addr[PG_W-1:0] == PG_LAST);
        close          = read_mode_next ? final_byte : (final_byte || page_end);

        job.hdr      = !open_now;
        job.rd       = read_mode_next;
        job.addr     = addr;
        job.data     = read_mode_next ? DUMMY_BYTE : write_data;
        job.sel_end  = close;
        job.wait_rdy = close && !read_mode_next;

        frame_open_next   = !close;
        next_address_next = addr + ADDR_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_address_reg <= '0;
            frame_open_reg   <= 1'b0;
            read_mode_reg    <= 1'b0;
        end else if (push) begin
            next_address_reg <= next_address_next;
            frame_open_reg   <= frame_open_next;
            read_mode_reg    <= read_mode_next;
        end
    end

endmodule

[hw/rtl/sfpf_back.sv]
module sfpf_back
    import sfpf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  job_t              job,
    input  q_status_t         q_status,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // spi_byte
    output logic [3:0]        m_tuser,   // select_begin, select_end, wait_ready, capture
    output logic              m_tlast
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] cur_step;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [3:0]        user_reg, user_next;
    logic              last_reg, last_next;
    logic              load;

    assign load     = !q_status.empty && (!valid_reg || m_tready);
    assign cur_step = job.hdr ? step_reg : STEP_DATA;
    assign pop      = load && (cur_step == STEP_DATA);

    always_comb begin
        byte_next = job.data;
        user_next = 4'b0000;
        last_next = 1'b0;
        step_next = step_reg;
        case (cur_step)
            STEP_CMD: begin
                byte_next = job.rd ? CMD_READ : CMD_PROGRAM;
                user_next = 4'b0001;
            end
            STEP_ADDR_HI:  byte_next = job.addr[23:16];
            STEP_ADDR_MID: byte_next = job.addr[15:8];
            STEP_ADDR_LO:  byte_next = job.addr[7:0];
            default: begin
                byte_next = job.data;
                user_next = {job.rd, job.wait_rdy, job.sel_end, 1'b0};
                last_next = 1'b1;
            end
        endcase
        if (load) begin
            step_next = (cur_step == STEP_DATA) ? STEP_CMD : step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_CMD;
            valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            user_reg <= user_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

import sfpf_pkg::*;

typedef struct {
    logic [7:0] spi_byte;
    bit         select_begin;
    bit         select_end;
    bit         wait_ready;
    bit         capture;
    bit         last;
} flash_byte_t;

class page_frame_tracker;
    logic [ADDR_W-1:0] next_addr;
    bit                frame_open;
    bit                read_mode;
    flash_byte_t       bytes_due[$];
    int                fails;
    int                n_in;
    int                n_out;
    int                n_frames;
    int                n_splits;
    int                n_reads;

    function new();
        next_addr  = '0;
        frame_open = 1'b0;
        read_mode  = 1'b0;
        fails      = 0;
        n_in       = 0;
        n_out      = 0;
        n_frames   = 0;
        n_splits   = 0;
        n_reads    = 0;
    endfunction

    function void push_byte(logic [7:0] b, bit sb, bit se, bit wr, bit cap, bit lst);
        flash_byte_t e;
        e.spi_byte     = b;
        e.select_begin = sb;
        e.select_end   = se;
        e.wait_ready   = wr;
        e.capture      = cap;
        e.last         = lst;
        bytes_due.push_back(e);
    endfunction

    // predicts the bus bytes caused by one accepted buffer byte
    function void take_buffer_byte(bit op, logic [ADDR_W-1:0] addr_in, logic [7:0] wdata,
                                   bit first_b, bit fin_b);
        logic [ADDR_W-1:0] addr;
        bit                page_end;
        bit                close_f;
        n_in++;
        if (first_b) begin
            read_mode  = op;
            next_addr  = addr_in;
            frame_open = 1'b0;
        end
        addr = next_addr;
        if (!frame_open) begin
            n_frames++;
            push_byte(read_mode ? CMD_READ : CMD_PROGRAM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(addr[23:16], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(addr[7:0], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            frame_open = 1'b1;
        end
        if (read_mode) begin
            n_reads++;
            push_byte(DUMMY_BYTE, 1'b0, fin_b, 1'b0, 1'b1, 1'b1);
            if (fin_b)
                frame_open = 1'b0;
        end else begin
            page_end = (addr % PAGE_BYTES_DEF) == (PAGE_BYTES_DEF - 1);
            close_f  = fin_b || page_end;
            if (page_end && !fin_b)
                n_splits++;
            push_byte(wdata, 1'b0, close_f, close_f, 1'b0, 1'b1);
            if (close_f)
                frame_open = 1'b0;
        end
        next_addr = addr + 1'b1;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            fails++;
        end
    endfunction

    function void match_bus_byte(logic [7:0] b, logic [3:0] u, logic lst);
        flash_byte_t e;
        n_out++;
        if (bytes_due.size() == 0) begin
            $error("output transaction %h with nothing expected", b);
            fails++;
            return;
        end
        e = bytes_due.pop_front();
        check_field("spi_byte", e.spi_byte, b);
        check_field("select_begin", 8'(e.select_begin), 8'(u[0]));
        check_field("select_end", 8'(e.select_end), 8'(u[1]));
        check_field("wait_ready", 8'(e.wait_ready), 8'(u[2]));
        check_field("capture", 8'(e.capture), 8'(u[3]));
        check_field("last", 8'(e.last), 8'(lst));
    endfunction
endclass

module tb_top;
    localparam bit OP_WRITE = 1'b0;
    localparam bit OP_READ  = 1'b1;
    localparam int N_DIRECTED = 17;
    localparam int N_RANDOM   = 113;
    localparam int IDLE_LIMIT = 400;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    page_frame_tracker tracker = new();

    int items_sent = 0;
    int burst_left = 1;
    int rx_cycle   = 0;
    int rx_mode    = 0;

    spi_flash_page_split_framer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // receiver stall pattern, one of four modes drawn at random from time to time
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 80 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (rx_cycle % 5) != 0;
            end
            default: begin
                m_tready <= $urandom_range(0, 9) < 2;
            end
        endcase
    end

    // output checked before input noted: a result never comes from the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                tracker.match_bus_byte(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                tracker.take_buffer_byte(s_tuser[0], s_tdata[23:0], s_tdata[31:24],
                                         s_tuser[1], s_tlast);
        end
    end

    task automatic send_byte(input bit op, input logic [23:0] addr, input logic [7:0] wdata,
                             input bit first_b, input bit fin_b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {wdata, addr};
        s_tuser  <= {first_b, op};
        s_tlast  <= fin_b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // well-formed transfer; later bytes carry random op and address bits
    task automatic send_transfer(input int len, input logic [23:0] base, input bit op);
        int i;
        for (i = 0; i < len; i++) begin
            if (i == 0)
                send_byte(op, base, 8'($urandom_range(0, 255)), 1'b1, len == 1);
            else
                send_byte(1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)),
                          8'($urandom_range(0, 255)), 1'b0, i == len - 1);
        end
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int len;
        logic [23:0] base;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = 30;

        // single-byte write at address zero
        send_byte(OP_WRITE, 24'h000000, 8'h00, 1'b1, 1'b1);
        // write crossing a page end
        send_byte(OP_WRITE, 24'h0001FE, 8'hFF, 1'b1, 1'b0);
        send_byte(OP_READ,  24'hFFFFFF, 8'h5A, 1'b0, 1'b0);
        send_byte(OP_WRITE, 24'h000000, 8'h3C, 1'b0, 1'b0);
        send_byte(OP_WRITE, 24'hFFFFFF, 8'h81, 1'b0, 1'b1);
        // address wrap, mode bit flipped mid transfer
        send_byte(OP_WRITE, 24'hFFFFFF, 8'hAA, 1'b1, 1'b0);
        send_byte(OP_READ,  24'h123456, 8'h55, 1'b0, 1'b1);
        // bytes with no transfer open
        send_byte(OP_READ,  24'hABCDEF, 8'h0F, 1'b0, 1'b0);
        send_byte(OP_WRITE, 24'h000000, 8'hF0, 1'b0, 1'b1);
        // read across a page end is not split
        send_byte(OP_READ,  24'h0001FF, 8'hFF, 1'b1, 1'b0);
        send_byte(OP_WRITE, 24'h000000, 8'h00, 1'b0, 1'b0);
        send_byte(OP_WRITE, 24'h000000, 8'h00, 1'b0, 1'b1);
        send_byte(OP_WRITE, 24'h000000, 8'h77, 1'b0, 1'b1);
        // new transfers while a frame is open
        send_byte(OP_WRITE, 24'h123456, 8'h12, 1'b1, 1'b0);
        send_byte(OP_READ,  24'hABCDEF, 8'h34, 1'b1, 1'b0);
        send_byte(OP_WRITE, 24'h00FF00, 8'h56, 1'b1, 1'b1);
        send_byte(OP_READ,  24'hFFFFFF, 8'hFF, 1'b1, 1'b1);

        while (items_sent < N_DIRECTED + N_RANDOM) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                // noise: an isolated byte of any shape
                send_byte(1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
                case ($urandom_range(0, 3))
                    0, 1: begin
                        base = {15'($urandom_range(0, 16'h7FFF)), 9'd0}
                               - 24'($urandom_range(1, 8));
                    end
                    2: begin
                        base = 24'hFFFFFF - 24'($urandom_range(0, 6));
                    end
                    default: begin
                        base = 24'($urandom_range(0, 24'hFFFFFF));
                    end
                endcase
                send_transfer(len, base, 1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        while (tracker.bytes_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d buffer bytes, %0d bus bytes, %0d frames", tracker.n_in,
                 tracker.n_out, tracker.n_frames);
        $display("page splits %0d, read bytes %0d, mismatches %0d", tracker.n_splits,
                 tracker.n_reads, tracker.fails);
        if (tracker.fails == 0 && tracker.bytes_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
